// ----- rtl/frlp_pkg.sv -----
// frlp_pkg: shared types and constants of the fair rate limited picker
// transaction structs, slot table sizing and sequencer states
// no dependencies
package frlp_pkg;

  localparam int Slots     = 8;
  localparam int SlotIdxW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int IdW       = 8;
  localparam int ValueW    = 32;
  localparam int TimeW     = 48;
  localparam int IntervalW = 32;

  localparam logic [IntervalW-1:0] DefaultIntervalUs = IntervalW'(20 * 1000);

  // depth of the small queues between the parts
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic              link_ready;
    logic [IdW-1:0]    sensor_id;
    logic [ValueW-1:0] reading_value;
    logic [TimeW-1:0]  time_us;
  } in_t;

  // reading that passed the front, link state already checked
  typedef struct packed {
    logic [IdW-1:0]    sensor_id;
    logic [ValueW-1:0] reading_value;
    logic [TimeW-1:0]  time_us;
  } item_t;

  typedef struct packed {
    logic [IdW-1:0]    out_sensor_id;
    logic [ValueW-1:0] out_value;
    logic              bypass;
  } out_t;

  // handshake between front queue and back sequencer
  typedef struct packed {
    logic valid;
    logic pop;
  } hs_t;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StScan,
    StEmit
  } state_e;

endpackage

// ----- rtl/frlp_front.sv -----
// frlp_front: input side of the picker, drops readings taken while the link is down
// and buffers the others in a two-entry queue; uses frlp_pkg
module frlp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  frlp_pkg::in_t  in_item_i,
  output logic           valid_o,
  input  logic           pop_i,
  output frlp_pkg::item_t item_o
);

  frlp_pkg::item_t mem_q [frlp_pkg::QDepth];
  logic [frlp_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [frlp_pkg::QCntW-1:0] cnt_q;
  logic wr, rd;

  assign full    = (cnt_q == frlp_pkg::QCntW'(frlp_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  // link down: transaction taken but nothing stored
  assign wr      = push && !full && in_item_i.link_ready;
  assign rd      = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= wr_ptr_q + frlp_pkg::QPtrW'(1);
      if (rd) rd_ptr_q <= rd_ptr_q + frlp_pkg::QPtrW'(1);
      if (wr && !rd) cnt_q <= cnt_q + frlp_pkg::QCntW'(1);
      else if (rd && !wr) cnt_q <= cnt_q - frlp_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q].sensor_id     <= in_item_i.sensor_id;
      mem_q[wr_ptr_q].reading_value <= in_item_i.reading_value;
      mem_q[wr_ptr_q].time_us       <= in_item_i.time_us;
    end
  end

endmodule

// ----- rtl/frlp_out_q.sv -----
// frlp_out_q: two-entry result queue between the back sequencer and the receiver
// uses frlp_pkg
module frlp_out_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  frlp_pkg::out_t item_i,
  output logic           full_o,
  output logic           empty,
  input  logic           pop,
  output frlp_pkg::out_t out_item_o
);

  frlp_pkg::out_t mem_q [frlp_pkg::QDepth];
  logic [frlp_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [frlp_pkg::QCntW-1:0] cnt_q;
  logic wr, rd;

  assign full_o     = (cnt_q == frlp_pkg::QCntW'(frlp_pkg::QDepth));
  assign empty      = (cnt_q == '0);
  assign wr         = push_i && !full_o;
  assign rd         = pop && !empty;
  assign out_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= wr_ptr_q + frlp_pkg::QPtrW'(1);
      if (rd) rd_ptr_q <= rd_ptr_q + frlp_pkg::QPtrW'(1);
      if (wr && !rd) cnt_q <= cnt_q + frlp_pkg::QCntW'(1);
      else if (rd && !wr) cnt_q <= cnt_q - frlp_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

// ----- rtl/frlp_back.sv -----
// frlp_back: slot table and sequencer, lookup or allocation, rate cap check,
// oldest pending scan one slot a cycle and emission; uses frlp_pkg
module frlp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [frlp_pkg::IntervalW-1:0]    cfg_wdata_i,
  output frlp_pkg::hs_t                     front_hs_o,
  input  logic                              item_valid_i,
  input  frlp_pkg::item_t                   item_i,
  input  logic                              out_full_i,
  output logic                              out_push_o,
  output frlp_pkg::out_t                    out_item_o
);

  localparam logic [frlp_pkg::SlotIdxW-1:0] LastIdx = frlp_pkg::SlotIdxW'(frlp_pkg::Slots - 1);

  frlp_pkg::state_e state_q, state_d;
  frlp_pkg::item_t  item_q;

  logic [frlp_pkg::Slots-1:0]      used_q, pending_q;
  logic [frlp_pkg::IdW-1:0]        sensor_q [frlp_pkg::Slots];
  logic [frlp_pkg::ValueW-1:0]     value_q  [frlp_pkg::Slots];
  logic [frlp_pkg::TimeW-1:0]      last_q   [frlp_pkg::Slots];
  logic [frlp_pkg::TimeW-1:0]      last_emit_q;
  logic [frlp_pkg::IntervalW-1:0]  interval_q;

  logic [frlp_pkg::SlotIdxW-1:0]   idx_q, best_idx_q;
  logic                            best_valid_q;
  logic [frlp_pkg::TimeW-1:0]      best_time_q;

  logic                            hit, free_found, cap_open, cand, take;
  logic [frlp_pkg::SlotIdxW-1:0]   hit_idx, free_idx;
  logic [frlp_pkg::TimeW-1:0]      elapsed;
  logic                            pop, emit;

  // parallel match and lowest free slot
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = frlp_pkg::Slots - 1; i >= 0; i--) begin
      if (used_q[i] && (sensor_q[i] == item_q.sensor_id)) begin
        hit     = 1'b1;
        hit_idx = frlp_pkg::SlotIdxW'(i);
      end
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = frlp_pkg::SlotIdxW'(i);
      end
    end
  end

  // rate cap; a zero emit time means nothing sent yet
  assign elapsed  = item_q.time_us - last_emit_q;
  assign cap_open = (last_emit_q == '0) ||
                    ((item_q.time_us >= last_emit_q) &&
                     (elapsed >= frlp_pkg::TimeW'(interval_q)));

  assign cand = used_q[idx_q] && pending_q[idx_q];
  assign take = cand && (!best_valid_q || (last_q[idx_q] < best_time_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      frlp_pkg::StIdle:   if (item_valid_i) state_d = frlp_pkg::StLookup;
      frlp_pkg::StLookup: state_d = cap_open ? frlp_pkg::StScan : frlp_pkg::StIdle;
      frlp_pkg::StScan:   if (idx_q == LastIdx) state_d = frlp_pkg::StEmit;
      frlp_pkg::StEmit:   if (!out_full_i) state_d = frlp_pkg::StIdle;
      default:            state_d = frlp_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    case (state_q)
      frlp_pkg::StIdle: pop  = item_valid_i;
      frlp_pkg::StEmit: emit = !out_full_i;
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign front_hs_o.valid = item_valid_i;
  assign front_hs_o.pop   = pop;
  assign out_push_o       = emit;

  always_comb begin
    if (best_valid_q) begin
      out_item_o.out_sensor_id = sensor_q[best_idx_q];
      out_item_o.out_value     = value_q[best_idx_q];
      out_item_o.bypass        = 1'b0;
    end else begin
      out_item_o.out_sensor_id = item_q.sensor_id;
      out_item_o.out_value     = item_q.reading_value;
      out_item_o.bypass        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= frlp_pkg::StIdle;
      used_q       <= '0;
      pending_q    <= '0;
      last_emit_q  <= '0;
      interval_q   <= frlp_pkg::DefaultIntervalUs;
      idx_q        <= '0;
      best_idx_q   <= '0;
      best_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        interval_q <= (cfg_wdata_i != '0) ? cfg_wdata_i : frlp_pkg::DefaultIntervalUs;
      end
      if (state_q == frlp_pkg::StLookup) begin
        idx_q        <= '0;
        best_valid_q <= 1'b0;
        if (hit) begin
          pending_q[hit_idx] <= 1'b1;
        end else if (free_found) begin
          used_q[free_idx]    <= 1'b1;
          pending_q[free_idx] <= 1'b1;
        end
      end
      if (state_q == frlp_pkg::StScan) begin
        idx_q <= idx_q + frlp_pkg::SlotIdxW'(1);
        if (take) begin
          best_valid_q <= 1'b1;
          best_idx_q   <= idx_q;
        end
      end
      if (emit) begin
        last_emit_q <= item_q.time_us;
        if (best_valid_q) pending_q[best_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) item_q <= item_i;
    if (state_q == frlp_pkg::StLookup) begin
      if (hit) begin
        value_q[hit_idx] <= item_q.reading_value;
      end else if (free_found) begin
        sensor_q[free_idx] <= item_q.sensor_id;
        value_q[free_idx]  <= item_q.reading_value;
        last_q[free_idx]   <= '0;
      end
    end
    if ((state_q == frlp_pkg::StScan) && take) best_time_q <= last_q[idx_q];
    if (emit && best_valid_q) last_q[best_idx_q] <= item_q.time_us;
  end

  // picked slot is always a live pending one
  a_best_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == frlp_pkg::StEmit) && best_valid_q) |->
      (used_q[best_idx_q] && pending_q[best_idx_q]))
    else $error("picked slot not pending");

  // bypass only with a full table and nothing pending
  a_bypass_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !best_valid_q) |-> ((&used_q) && (pending_q == '0)))
    else $error("bypass with room or pending slot");

  // a served slot loses its pending mark
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && best_valid_q) |=> !pending_q[$past(best_idx_q)])
    else $error("served slot still pending");

  // emit time moves only on emission
  a_emit_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !emit |=> $stable(last_emit_q))
    else $error("emit time changed without emission");

endmodule

// ----- rtl/fair_rate_limited_picker_top.sv -----
// fair_rate_limited_picker_top: top level of the fair rate limited picker
// instantiates frlp_front, frlp_back and frlp_out_q; uses frlp_pkg
//
// usage
//   input channel: a reading transaction is taken at a rising edge with push high
//     and full low; readings with link_ready low are taken and dropped
//   result channel: while empty is low the oldest result sits on out_item_o,
//     pop high at a rising edge takes it
//   config: cfg_we_i high at a rising edge loads cfg_wdata_i into the minimum
//     interval; a zero write loads the default of 20000 us
// sequencing
//   one reading at a time in the back sequencer: dequeue, slot lookup and cap
//     check, oldest pending scan over all Slots slots (one slot per cycle
//     through a 48-bit compare), then emit, held while the output queue is full
//   a reading blocked by the rate cap leaves after the lookup with no result
//   two readings queue at the input and two results at the output
// reset
//   all slots free, nothing pending, never sent, interval 20000 us, queues empty
// receiver stall
//   results wait in the output queue; once it is full the sequencer holds in
//   emit, the input queue fills and full rises
module fair_rate_limited_picker_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  frlp_pkg::in_t                  in_item_i,
  output logic                           empty,
  input  logic                           pop,
  output frlp_pkg::out_t                 out_item_o,
  input  logic                           cfg_we_i,
  input  logic [frlp_pkg::IntervalW-1:0] cfg_wdata_i
);

  frlp_pkg::hs_t   front_hs;
  logic            item_valid;
  frlp_pkg::item_t item;
  logic            oq_full;
  logic            oq_push;
  frlp_pkg::out_t  oq_item;

  // front: classify and buffer reading transactions
  frlp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .valid_o   (item_valid),
    .pop_i     (front_hs.pop),
    .item_o    (item)
  );

  // back: slot table, rate cap and least recently served pick
  frlp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .front_hs_o   (front_hs),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_full_i   (oq_full),
    .out_push_o   (oq_push),
    .out_item_o   (oq_item)
  );

  // result queue toward the receiver
  frlp_out_q u_out_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (oq_push),
    .item_i     (oq_item),
    .full_o     (oq_full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule
